FILE: src/onc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral normal codec package
// Shared widths, stage counts, codes and result records.
// ----------------------------------------------------------------------------
package onc_pkg;

   localparam int DATA_W    = 16;  // width of every payload field
   localparam int L1_W      = 17;  // |x|+|y|+|z| of 16-bit components
   localparam int W_W       = 18;  // shifted coordinate, 0 .. 2*l1
   localparam int MAG_W     = 16;  // decoded component magnitude after scaling
   localparam int SQ_W      = 32;  // square of a magnitude
   localparam int LEN_W     = 34;  // sum of three squares
   localparam int ACC_W     = 68;  // root search accumulators
   localparam int ROOT_BITS = 15;  // result magnitude bits, 0 .. 16384
   localparam int ROOT_SHIFT = 30; // (2q-1)^2 * len2 <= m^2 * 2^30

   localparam int ENC_FRONT  = 3;  // abs/l1, fold, numerator
   localparam int DEC_FRONT  = 5;  // unpack, unfold, scale, square, sum
   localparam int DEC_STAGES = DEC_FRONT + ROOT_BITS;

   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] u;
      logic [DATA_W-1:0] v;
      logic              zero_vector;
   } enc_result_type;

   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] z;
   } dec_result_type;

endpackage

FILE: src/onc_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral encoder pipeline
// L1 projection, lower hemisphere fold and a restoring divider, one
// quotient bit per stage, for both code coordinates.
// ----------------------------------------------------------------------------
module onc_encode #(
   parameter int CODE_BITS = 16,
   parameter int STAGES    = 20
) (
   input  logic                   clock,
   input  logic [STAGES-1:0]      stage_ld,
   input  logic signed [15:0]     normal_x,
   input  logic signed [15:0]     normal_y,
   input  logic signed [15:0]     normal_z,
   output onc_pkg::enc_result_type result
);

   localparam int L1_W = onc_pkg::L1_W;
   localparam int W_W  = onc_pkg::W_W;
   localparam int D_W  = onc_pkg::W_W;
   localparam int N_W  = onc_pkg::W_W + CODE_BITS;
   localparam int CORE = onc_pkg::ENC_FRONT + CODE_BITS;
   localparam int PAD  = STAGES - CORE;
   localparam logic [CODE_BITS-1:0] MID_CODE = {1'b1, {(CODE_BITS-1){1'b0}}};

   // stage 0: magnitudes and L1 norm
   logic [L1_W-1:0] ax_c, ay_c, az_c, l1_in;
   logic [L1_W-1:0] l1_ff;
   logic            zneg_ff;
   logic signed [15:0] val_ff [2];
   logic [L1_W-1:0]    oth_ff [2];

   always_comb begin
      ax_c  = normal_x[15] ? (L1_W'(0) - {normal_x[15], normal_x}) : {1'b0, normal_x};
      ay_c  = normal_y[15] ? (L1_W'(0) - {normal_y[15], normal_y}) : {1'b0, normal_y};
      az_c  = normal_z[15] ? (L1_W'(0) - {normal_z[15], normal_z}) : {1'b0, normal_z};
      l1_in = ax_c + ay_c + az_c;
   end

   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         l1_ff     <= l1_in;
         zneg_ff   <= normal_z[15];
         val_ff[0] <= normal_x;
         val_ff[1] <= normal_y;
         oth_ff[0] <= ay_c;
         oth_ff[1] <= ax_c;
      end
   end

   // stage 1 carries l1, stage 2 builds the divisor
   logic [L1_W-1:0] l1b_ff;
   logic [D_W-1:0]  den_ff  [CODE_BITS];
   logic            zero_ff [CODE_BITS+1];

   always_ff @(posedge clock) begin
      if (stage_ld[1]) begin
         l1b_ff <= l1_ff;
      end
      if (stage_ld[2]) begin
         den_ff[0]  <= {l1b_ff, 1'b0};
         zero_ff[0] <= (l1b_ff == '0);
      end
   end

   for (genvar k = 0; k < CODE_BITS; k++) begin : g_carry
      always_ff @(posedge clock) begin
         if (stage_ld[onc_pkg::ENC_FRONT+k]) begin
            zero_ff[k+1] <= zero_ff[k];
         end
      end
      if (k < CODE_BITS - 1) begin : g_den
         always_ff @(posedge clock) begin
            if (stage_ld[onc_pkg::ENC_FRONT+k]) begin
               den_ff[k+1] <= den_ff[k];
            end
         end
      end
   end

   logic [CODE_BITS-1:0] code_c [2];

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [W_W-1:0]       w_in, w_ff;
      logic signed [W_W:0]  sum_c;
      logic [N_W-1:0]       num_in;
      logic [N_W-1:0]       rem_ff [CODE_BITS];
      logic [CODE_BITS-1:0] q_ff   [CODE_BITS+1];

      // w = n + l1, the coordinate shifted onto 0 .. 2*l1
      always_comb begin
         sum_c = $signed({{3{val_ff[l][15]}}, val_ff[l]}) + $signed({2'b00, l1_ff});
         if (!zneg_ff) begin
            w_in = sum_c[W_W-1:0];
         end else if (val_ff[l][15]) begin
            w_in = {1'b0, oth_ff[l]};
         end else begin
            w_in = {l1_ff, 1'b0} - {1'b0, oth_ff[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ld[1]) begin
            w_ff <= w_in;
         end
      end

      // w * CODE_MAX + l1
      assign num_in = {w_ff, {CODE_BITS{1'b0}}} - {{CODE_BITS{1'b0}}, w_ff}
                    + {{(N_W-L1_W){1'b0}}, l1b_ff};

      always_ff @(posedge clock) begin
         if (stage_ld[2]) begin
            rem_ff[0] <= num_in;
            q_ff[0]   <= '0;
         end
      end

      for (genvar k = 0; k < CODE_BITS; k++) begin : g_div
         localparam int SH = CODE_BITS - 1 - k;
         logic [N_W-1:0] dsh_c;
         logic           ge_c;

         always_comb begin
            dsh_c = {{(N_W-D_W){1'b0}}, den_ff[k]} << SH;
            ge_c  = (rem_ff[k] >= dsh_c);
         end

         always_ff @(posedge clock) begin
            if (stage_ld[onc_pkg::ENC_FRONT+k]) begin
               q_ff[k+1] <= {q_ff[k][CODE_BITS-2:0], ge_c};
            end
         end

         if (k < CODE_BITS - 1) begin : g_rem
            always_ff @(posedge clock) begin
               if (stage_ld[onc_pkg::ENC_FRONT+k]) begin
                  rem_ff[k+1] <= ge_c ? (rem_ff[k] - dsh_c) : rem_ff[k];
               end
            end
         end
      end

      assign code_c[l] = zero_ff[CODE_BITS] ? MID_CODE : q_ff[CODE_BITS];
   end

   logic [CODE_BITS+15:0]   u_ext, v_ext;
   onc_pkg::enc_result_type core_res;

   always_comb begin
      u_ext                = {16'd0, code_c[0]};
      v_ext                = {16'd0, code_c[1]};
      core_res.u           = u_ext[15:0];
      core_res.v           = v_ext[15:0];
      core_res.zero_vector = zero_ff[CODE_BITS];
   end

   if (PAD > 0) begin : g_pad
      onc_pkg::enc_result_type pad_ff [PAD];
      for (genvar p = 0; p < PAD; p++) begin : g_stage
         if (p == 0) begin : g_head
            always_ff @(posedge clock) begin
               if (stage_ld[CORE]) pad_ff[0] <= core_res;
            end
         end else begin : g_tail
            always_ff @(posedge clock) begin
               if (stage_ld[CORE+p]) pad_ff[p] <= pad_ff[p-1];
            end
         end
      end
      assign result = pad_ff[PAD-1];
   end else begin : g_nopad
      assign result = core_res;
   end

endmodule

FILE: src/onc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral decoder pipeline
// Unfold of the code pair, squared length, and a per-component digit search
// for round(16384 * m / |n|), one result bit per stage.
// ----------------------------------------------------------------------------
module onc_decode #(
   parameter int CODE_BITS = 16,
   parameter int STAGES    = 20
) (
   input  logic                   clock,
   input  logic [STAGES-1:0]      stage_ld,
   input  logic [15:0]            code_u,
   input  logic [15:0]            code_v,
   output onc_pkg::dec_result_type result
);

   localparam int F_W   = CODE_BITS + 2;
   localparam int C_W   = CODE_BITS + 16;
   localparam int SHIFT = (CODE_BITS > 16) ? (CODE_BITS - 16) : 0;
   localparam int MAG_W = onc_pkg::MAG_W;
   localparam int SQ_W  = onc_pkg::SQ_W;
   localparam int LEN_W = onc_pkg::LEN_W;
   localparam int ACC_W = onc_pkg::ACC_W;
   localparam int RB    = onc_pkg::ROOT_BITS;
   localparam int FRONT = onc_pkg::DEC_FRONT;
   localparam int CORE  = onc_pkg::DEC_STAGES;
   localparam int PAD   = STAGES - CORE;
   localparam logic [CODE_BITS-1:0] CODE_MAX = '1;

   // stage 0: saturate codes, f = 2c - CODE_MAX
   logic [C_W-1:0]        cmax_ext, cu_ext, cv_ext, cu_sat, cv_sat;
   logic signed [F_W-1:0] fx_in, fy_in, fx_ff, fy_ff;

   always_comb begin
      cmax_ext = {16'd0, CODE_MAX};
      cu_ext   = {{CODE_BITS{1'b0}}, code_u};
      cv_ext   = {{CODE_BITS{1'b0}}, code_v};
      cu_sat   = (cu_ext > cmax_ext) ? cmax_ext : cu_ext;
      cv_sat   = (cv_ext > cmax_ext) ? cmax_ext : cv_ext;
      fx_in    = $signed({1'b0, cu_sat[CODE_BITS-1:0], 1'b0}) - $signed({2'b00, CODE_MAX});
      fy_in    = $signed({1'b0, cv_sat[CODE_BITS-1:0], 1'b0}) - $signed({2'b00, CODE_MAX});
   end

   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
      end
   end

   // stage 1: nz and the fold term pulled toward zero
   logic signed [F_W-1:0] ax_c, ay_c, nz_c, t_c;
   logic signed [F_W-1:0] n_in [3];
   logic signed [F_W-1:0] n_ff [3];

   always_comb begin
      ax_c    = fx_ff[F_W-1] ? -fx_ff : fx_ff;
      ay_c    = fy_ff[F_W-1] ? -fy_ff : fy_ff;
      nz_c    = $signed({2'b00, CODE_MAX}) - ax_c - ay_c;
      t_c     = nz_c[F_W-1] ? -nz_c : '0;
      n_in[0] = fx_ff[F_W-1] ? (fx_ff + t_c) : (fx_ff - t_c);
      n_in[1] = fy_ff[F_W-1] ? (fy_ff + t_c) : (fy_ff - t_c);
      n_in[2] = nz_c;
   end

   always_ff @(posedge clock) begin
      if (stage_ld[1]) begin
         n_ff <= n_in;
      end
   end

   logic [SQ_W-1:0]  sq_ff  [3];
   logic [SQ_W-1:0]  sq4_ff [3];
   logic             neg3_ff [3];
   logic             neg4_ff [3];
   logic [LEN_W-1:0] len2_ff;
   logic [LEN_W-1:0] len_c_ff [RB];
   logic [15:0]      unit_c [3];

   // stage 4: squared length
   always_ff @(posedge clock) begin
      if (stage_ld[4]) begin
         len2_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
         sq4_ff  <= sq_ff;
         neg4_ff <= neg3_ff;
      end
   end

   for (genvar j = 0; j < RB; j++) begin : g_len
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (stage_ld[FRONT]) len_c_ff[0] <= len2_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (stage_ld[FRONT+j]) len_c_ff[j] <= len_c_ff[j-1];
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [F_W-1:0]       abs_c;
      logic [F_W+15:0]      mag_ext;
      logic [MAG_W-1:0]     m_ff;
      logic                 neg2_ff;
      logic signed [ACC_W-1:0] p_ff [RB-1];
      logic signed [ACC_W-1:0] s_ff [RB-1];
      logic [RB-1:0]        q_ff [RB];
      logic [SQ_W-1:0]      sqc_ff [RB-1];
      logic                 negc_ff [RB];
      logic [15:0]          mag16;

      // stage 2: magnitude, scaled down for wide codes
      always_comb begin
         abs_c   = n_ff[l][F_W-1] ? F_W'(-n_ff[l]) : F_W'(n_ff[l]);
         mag_ext = {16'd0, abs_c} >> SHIFT;
      end

      always_ff @(posedge clock) begin
         if (stage_ld[2]) begin
            m_ff    <= mag_ext[MAG_W-1:0];
            neg2_ff <= n_ff[l][F_W-1];
         end
         if (stage_ld[3]) begin
            sq_ff[l]   <= m_ff * m_ff;
            neg3_ff[l] <= neg2_ff;
         end
      end

      // Greedy search for the largest q with (2q-1)^2 * len2 <= m^2 << 30.
      // P = d^2 * len2 and S = d * len2 with d = 2q-1 are kept by adds only.
      for (genvar j = 0; j < RB; j++) begin : g_iter
         localparam int B = RB - 1 - j;
         logic signed [ACC_W-1:0] p_cur, s_cur, len_a, pc_c, r_c;
         logic [RB-1:0]           q_cur;
         logic [SQ_W-1:0]         sq_cur;
         logic [LEN_W-1:0]        len_cur;
         logic                    neg_cur, take_c;

         if (j == 0) begin : g_first
            assign len_cur = len2_ff;
            assign p_cur   = $signed({{(ACC_W-LEN_W){1'b0}}, len2_ff});
            assign s_cur   = -$signed({{(ACC_W-LEN_W){1'b0}}, len2_ff});
            assign q_cur   = '0;
            assign sq_cur  = sq4_ff[l];
            assign neg_cur = neg4_ff[l];
         end else begin : g_next
            assign len_cur = len_c_ff[j-1];
            assign p_cur   = p_ff[j-1];
            assign s_cur   = s_ff[j-1];
            assign q_cur   = q_ff[j-1];
            assign sq_cur  = sqc_ff[j-1];
            assign neg_cur = negc_ff[j-1];
         end

         always_comb begin
            len_a  = $signed({{(ACC_W-LEN_W){1'b0}}, len_cur});
            pc_c   = p_cur + (s_cur <<< (B + 2)) + (len_a <<< (2 * B + 2));
            r_c    = $signed({{(ACC_W-SQ_W-onc_pkg::ROOT_SHIFT){1'b0}}, sq_cur,
                              {onc_pkg::ROOT_SHIFT{1'b0}}});
            take_c = (pc_c <= r_c);
         end

         always_ff @(posedge clock) begin
            if (stage_ld[FRONT+j]) begin
               q_ff[j]    <= q_cur | (RB'(take_c) << B);
               negc_ff[j] <= neg_cur;
            end
         end

         if (j < RB - 1) begin : g_acc
            always_ff @(posedge clock) begin
               if (stage_ld[FRONT+j]) begin
                  p_ff[j]   <= take_c ? pc_c : p_cur;
                  s_ff[j]   <= take_c ? (s_cur + (len_a <<< (B + 1))) : s_cur;
                  sqc_ff[j] <= sq_cur;
               end
            end
         end
      end

      always_comb begin
         mag16 = {1'b0, q_ff[RB-1]};
         if (len_c_ff[RB-1] == '0) begin
            unit_c[l] = '0;
         end else begin
            unit_c[l] = negc_ff[RB-1] ? (16'd0 - mag16) : mag16;
         end
      end
   end

   onc_pkg::dec_result_type core_res;

   always_comb begin
      core_res.x = unit_c[0];
      core_res.y = unit_c[1];
      core_res.z = unit_c[2];
   end

   if (PAD > 0) begin : g_pad
      onc_pkg::dec_result_type pad_ff [PAD];
      for (genvar p = 0; p < PAD; p++) begin : g_stage
         if (p == 0) begin : g_head
            always_ff @(posedge clock) begin
               if (stage_ld[CORE]) pad_ff[0] <= core_res;
            end
         end else begin : g_tail
            always_ff @(posedge clock) begin
               if (stage_ld[CORE+p]) pad_ff[p] <= pad_ff[p-1];
            end
         end
      end
      assign result = pad_ff[PAD-1];
   end else begin : g_nopad
      assign result = core_res;
   end

endmodule

FILE: src/octahedral_normal_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octahedral normal codec core
// Encodes Q1.14 normals to octahedral code pairs and decodes code pairs back
// to unit normals, one request per cycle through a shared pipeline unless the response stalls.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                         | tuser
//  req_    | in  | normal_x, normal_y, normal_z, code_u, code_v | kind
//  rsp_    | out | out_u, out_v, unit_x, unit_y, unit_z         | zero_vector
//
//  The depth follows the decoder, with its 15-step root search, or the encoder,
//  with its CODE_BITS-step divider, when that is longer, plus the output register.
//  Throughput is one request per cycle while rsp_tready stays high.
//  Every stage holds only when it is full and the stage after it holds, so
//  empty slots close up behind a stalled result. Reset clears the valid bits.
// ----------------------------------------------------------------------------
module octahedral_normal_codec_core #(
   parameter int CODE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // normal_x, normal_y, normal_z, code_u, code_v
   input  logic [0:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // out_u, out_v, unit_x, unit_y, unit_z
   output logic [0:0]  rsp_tuser   // zero_vector
);

   localparam int ENC_STAGES  = onc_pkg::ENC_FRONT + CODE_BITS;
   localparam int CORE_STAGES = (ENC_STAGES > onc_pkg::DEC_STAGES) ?
                                ENC_STAGES : onc_pkg::DEC_STAGES;
   localparam int DEPTH       = CORE_STAGES + 1;

   logic [DEPTH-1:0]       valid_ff, valid_in;
   logic [DEPTH:0]         ld;
   logic [CORE_STAGES-1:0] kind_ff, kind_in;
   logic [79:0]            rsp_data_ff, rsp_data_in;
   logic                   rsp_flag_ff, rsp_flag_in;

   onc_pkg::enc_result_type enc_res;
   onc_pkg::dec_result_type dec_res;

   assign ld[DEPTH] = rsp_tready;
   for (genvar k = 0; k < DEPTH; k++) begin : g_ld
      assign ld[k] = !valid_ff[k] || ld[k+1];
   end

   assign req_tready = ld[0];
   assign rsp_tvalid = valid_ff[DEPTH-1];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   always_comb begin
      valid_in = (ld[DEPTH-1:0] & {valid_ff[DEPTH-2:0], req_tvalid})
               | (~ld[DEPTH-1:0] & valid_ff);
      kind_in  = (ld[CORE_STAGES-1:0] & {kind_ff[CORE_STAGES-2:0], req_tuser[0]})
               | (~ld[CORE_STAGES-1:0] & kind_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   onc_encode #(
      .CODE_BITS (CODE_BITS),
      .STAGES    (CORE_STAGES)
   ) u_encode (
      .clock    (clock),
      .stage_ld (ld[CORE_STAGES-1:0]),
      .normal_x (req_tdata[15:0]),
      .normal_y (req_tdata[31:16]),
      .normal_z (req_tdata[47:32]),
      .result   (enc_res)
   );

   onc_decode #(
      .CODE_BITS (CODE_BITS),
      .STAGES    (CORE_STAGES)
   ) u_decode (
      .clock    (clock),
      .stage_ld (ld[CORE_STAGES-1:0]),
      .code_u   (req_tdata[63:48]),
      .code_v   (req_tdata[79:64]),
      .result   (dec_res)
   );

   always_comb begin
      if (kind_ff[CORE_STAGES-1] == onc_pkg::KIND_DECODE) begin
         rsp_data_in = {dec_res.z, dec_res.y, dec_res.x, 16'd0, 16'd0};
         rsp_flag_in = 1'b0;
      end else begin
         rsp_data_in = {16'd0, 16'd0, 16'd0, enc_res.v, enc_res.u};
         rsp_flag_in = enc_res.zero_vector;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[CORE_STAGES]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_flag_ff <= rsp_flag_in;
      end
   end

endmodule
